FILE: rtl/rgba_over_rgb565_compositor_defines.svh
// Assertion helpers shared by the RTL.
`ifndef RGBA_OVER_RGB565_COMPOSITOR_DEFINES_SVH
`define RGBA_OVER_RGB565_COMPOSITOR_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ROC_ASSERT_CLK(clk_i, rst_ni, label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent check on the module's clk and rst_n.
`define ROC_ASSERT(label, prop, msg) `ROC_ASSERT_CLK(clk, rst_n, label, prop, msg)

`endif

FILE: rtl/roc_pkg.sv
package roc_pkg;

  localparam int FRAME_MAX_DEF  = 512;
  localparam int TILE_SIZE_DEF  = 512;
  localparam int FRAME_SIZE_RST = 512;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;
  localparam int CFG_W      = 10;
  localparam int SIZE_W     = 11;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PASTE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_CLIPPED = 2'd1;
  localparam logic [1:0] ST_CLEAR   = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  typedef enum logic [1:0] {
    OP_CLIP,
    OP_LOAD,
    OP_PASTE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] base;
  } cmd_t;

  function automatic int addr_width(input int fm);
    return (fm * fm > 1) ? $clog2(fm * fm) : 1;
  endfunction

  function automatic int coord_width(input int fm);
    return (fm > 1) ? $clog2(fm) : 1;
  endfunction

  // c*255/31, truncated
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [2:0] f;
    f = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18) +
        3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
    return {c, 3'b000} + {5'b00000, f};
  endfunction

  // c*255/63, truncated
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] f;
    f = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
    return {c, 2'b00} + {6'b000000, f};
  endfunction

  // floor(x/255), exact for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'h000, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: rtl/roc_front.sv
module roc_front #(
  parameter int FRAME_MAX = roc_pkg::FRAME_MAX_DEF,
  parameter int TILE_SIZE = roc_pkg::TILE_SIZE_DEF,
  parameter int AW        = roc_pkg::addr_width(FRAME_MAX)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [roc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [roc_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           cfg_wr_en,
  input  logic [roc_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                           q_full,
  output logic                           push,
  output roc_pkg::cmd_t                  push_cmd,
  output logic [AW-1:0]                  push_addr
);

  localparam int CW = roc_pkg::coord_width(FRAME_MAX);
  localparam logic [roc_pkg::SIZE_W-1:0] FRAME_LIM = roc_pkg::SIZE_W'(FRAME_MAX);
  localparam logic [roc_pkg::SIZE_W-1:0] TILE_LIM  = roc_pkg::SIZE_W'(TILE_SIZE);
  localparam logic [roc_pkg::SIZE_W-1:0] SIZE_RST  = roc_pkg::SIZE_W'(
    (roc_pkg::FRAME_SIZE_RST < FRAME_MAX) ? roc_pkg::FRAME_SIZE_RST : FRAME_MAX);
  localparam logic [AW-1:0] ROW_PITCH = AW'(FRAME_MAX);

  logic [roc_pkg::SIZE_W-1:0] size_r;
  logic [roc_pkg::SIZE_W-1:0] cfg_size;
  logic [8:0]                 col;
  logic [8:0]                 row;
  logic [10:0]                ox;
  logic [10:0]                oy;
  logic [11:0]                px;
  logic [11:0]                py;
  logic [10:0]                fx;
  logic [10:0]                fy;
  roc_pkg::op_t               op;
  roc_pkg::cmd_t              cmd_nxt;
  logic [AW-1:0]              addr_nxt;
  logic                       in_acc;
  logic                       f_v_r;
  roc_pkg::cmd_t              f_cmd_r;
  logic [AW-1:0]              f_addr_r;

  assign col = in_tdata[8:0];
  assign row = in_tdata[17:9];
  assign ox  = in_tdata[28:18];
  assign oy  = in_tdata[39:29];
  assign px  = {ox[10], ox} + {3'b000, col};
  assign py  = {oy[10], oy} + {3'b000, row};

  assign cfg_size = {1'b0, cfg_wr_data};

  always_comb begin
    fx = {2'b00, col};
    fy = {2'b00, row};
    op = roc_pkg::OP_CLIP;
    case (in_tuser)
      roc_pkg::KIND_LOAD: begin
        if (fx < size_r && fy < size_r) op = roc_pkg::OP_LOAD;
      end
      roc_pkg::KIND_READ: begin
        if (fx < size_r && fy < size_r) op = roc_pkg::OP_READ;
      end
      roc_pkg::KIND_PASTE: begin
        fx = px[10:0];
        fy = py[10:0];
        if ({2'b00, col} < TILE_LIM && {2'b00, row} < TILE_LIM && !px[11] && !py[11] &&
            px[10:0] < size_r && py[10:0] < size_r) begin
          op = roc_pkg::OP_PASTE;
        end
      end
      default: op = roc_pkg::OP_CLIP;
    endcase
  end

  always_comb begin
    cmd_nxt.op    = op;
    cmd_nxt.red   = in_tdata[47:40];
    cmd_nxt.green = in_tdata[55:48];
    cmd_nxt.blue  = in_tdata[63:56];
    cmd_nxt.alpha = in_tdata[71:64];
    cmd_nxt.base  = in_tdata[87:72];
  end

  assign addr_nxt = AW'(fy[CW-1:0]) * ROW_PITCH + AW'(fx[CW-1:0]);

  assign in_tready = !f_v_r || !q_full;
  assign in_acc    = in_tvalid && in_tready;
  assign push      = f_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RST;
      f_v_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) size_r <= (cfg_size < FRAME_LIM) ? cfg_size : FRAME_LIM;
      if (in_acc) begin
        f_v_r <= 1'b1;
      end else if (push) begin
        f_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_cmd_r  <= cmd_nxt;
      f_addr_r <= addr_nxt;
    end
  end

  assign push_cmd  = f_cmd_r;
  assign push_addr = f_addr_r;

endmodule

FILE: rtl/roc_queue.sv
`include "rgba_over_rgb565_compositor_defines.svh"

module roc_queue #(
  parameter int AW = roc_pkg::addr_width(roc_pkg::FRAME_MAX_DEF)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  roc_pkg::cmd_t push_cmd,
  input  logic [AW-1:0] push_addr,
  output logic          full,
  output logic          head_valid,
  output roc_pkg::cmd_t head_cmd,
  output logic [AW-1:0] head_addr,
  input  logic          pop
);

  localparam logic [roc_pkg::FIFO_CNT_W-1:0] FULL_CNT =
    roc_pkg::FIFO_CNT_W'(roc_pkg::FIFO_DEPTH);

  roc_pkg::cmd_t                  cmd_mem  [roc_pkg::FIFO_DEPTH];
  logic [AW-1:0]                  addr_mem [roc_pkg::FIFO_DEPTH];
  logic [roc_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [roc_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [roc_pkg::FIFO_CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = cmd_mem[rd_ptr_r];
  assign head_addr  = addr_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr_r]  <= push_cmd;
      addr_mem[wr_ptr_r] <= push_addr;
    end
  end

  `ROC_ASSERT(a_no_overflow, push |-> (cnt_r != FULL_CNT), "push into full queue")
  `ROC_ASSERT(a_no_underflow, pop |-> (cnt_r != '0), "pop from empty queue")
  `ROC_ASSERT(a_cnt_grow, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "count lost a push")

endmodule

FILE: rtl/roc_back.sv
`include "rgba_over_rgb565_compositor_defines.svh"

module roc_back #(
  parameter int FRAME_MAX = roc_pkg::FRAME_MAX_DEF,
  parameter int AW        = roc_pkg::addr_width(FRAME_MAX)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  roc_pkg::cmd_t                  q_cmd,
  input  logic [AW-1:0]                  q_addr,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [roc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [roc_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int NPIX = FRAME_MAX * FRAME_MAX;

  logic [15:0]   frame_mem [NPIX];

  logic          s1_v_r;
  roc_pkg::cmd_t s1_cmd_r;
  logic [AW-1:0] s1_addr_r;
  logic [15:0]   rdata_r;
  logic [15:0]   sa_red_r;
  logic [15:0]   sa_green_r;
  logic [15:0]   sa_blue_r;

  logic          wr_v_r;
  logic [AW-1:0] wr_addr_r;
  logic [15:0]   wr_data_r;

  logic          out_v_r;
  logic [15:0]   out_pix_r;
  logic [1:0]    out_status_r;

  logic          s1_adv;
  logic          mem_we;
  logic [15:0]   d;
  logic [7:0]    dr;
  logic [7:0]    dg;
  logic [7:0]    db;
  logic [7:0]    ia;
  logic [15:0]   pr_red;
  logic [15:0]   pr_green;
  logic [15:0]   pr_blue;
  logic [15:0]   blend_pix;
  logic [15:0]   res_pix;
  logic [1:0]    res_status;
  logic          res_we;

  assign s1_adv = s1_v_r && (!out_v_r || out_tready);
  assign pop    = q_valid && (!s1_v_r || s1_adv);
  assign mem_we = s1_adv && res_we;

  // last write is not yet visible in rdata_r
  assign d  = (wr_v_r && wr_addr_r == s1_addr_r) ? wr_data_r : rdata_r;
  assign dr = roc_pkg::expand5(d[15:11]);
  assign dg = roc_pkg::expand6(d[10:5]);
  assign db = roc_pkg::expand5(d[4:0]);
  assign ia = ~s1_cmd_r.alpha;

  assign pr_red   = {8'h00, dr} * {8'h00, ia};
  assign pr_green = {8'h00, dg} * {8'h00, ia};
  assign pr_blue  = {8'h00, db} * {8'h00, ia};

  always_comb begin
    if (s1_cmd_r.alpha == 8'hFF) begin
      blend_pix = roc_pkg::pack565(s1_cmd_r.red, s1_cmd_r.green, s1_cmd_r.blue);
    end else begin
      blend_pix = roc_pkg::pack565(roc_pkg::div255(sa_red_r + pr_red),
                                   roc_pkg::div255(sa_green_r + pr_green),
                                   roc_pkg::div255(sa_blue_r + pr_blue));
    end
  end

  always_comb begin
    res_pix    = 16'h0000;
    res_status = roc_pkg::ST_CLIPPED;
    res_we     = 1'b0;
    case (s1_cmd_r.op)
      roc_pkg::OP_LOAD: begin
        res_pix    = s1_cmd_r.base;
        res_status = roc_pkg::ST_WRITTEN;
        res_we     = 1'b1;
      end
      roc_pkg::OP_READ: begin
        res_pix    = d;
        res_status = roc_pkg::ST_READ;
      end
      roc_pkg::OP_PASTE: begin
        if (s1_cmd_r.alpha == 8'h00) begin
          res_pix    = d;
          res_status = roc_pkg::ST_CLEAR;
        end else begin
          res_pix    = blend_pix;
          res_status = roc_pkg::ST_WRITTEN;
          res_we     = 1'b1;
        end
      end
      default: begin
        res_pix    = 16'h0000;
        res_status = roc_pkg::ST_CLIPPED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[s1_addr_r] <= res_pix;
    if (pop)    rdata_r <= frame_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      wr_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (mem_we) wr_v_r <= 1'b1;
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd_r   <= q_cmd;
      s1_addr_r  <= q_addr;
      sa_red_r   <= {8'h00, q_cmd.red} * {8'h00, q_cmd.alpha};
      sa_green_r <= {8'h00, q_cmd.green} * {8'h00, q_cmd.alpha};
      sa_blue_r  <= {8'h00, q_cmd.blue} * {8'h00, q_cmd.alpha};
    end
    if (mem_we) begin
      wr_addr_r <= s1_addr_r;
      wr_data_r <= res_pix;
    end
    if (s1_adv) begin
      out_pix_r    <= res_pix;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_status_r;

  `ROC_ASSERT(a_we_reports, mem_we |=> (out_v_r && out_status_r == roc_pkg::ST_WRITTEN), "write without written result")
  `ROC_ASSERT(a_stall_no_we, (out_v_r && !out_tready) |-> !mem_we, "memory written while output stalled")
  `ROC_ASSERT(a_out_hold, (out_v_r && !out_tready) |=> (out_v_r && $stable(out_pix_r)), "result dropped while stalled")

endmodule

FILE: rtl/rgba_over_rgb565_compositor.sv
// RGBA-over-RGB565 compositor over a FRAME_MAX x FRAME_MAX frame memory (one write and
// one read port, pixel at row*FRAME_MAX+col). Each input transaction loads, pastes
// (source-over, clipped) or reads one pixel and yields exactly one output transaction:
// pixel in out_tdata, status in out_tuser. Sustained rate is one transaction per clock
// while out_tready stays high. Between an accepted input transaction and out_tvalid lie
// the input register, the command queue, the registered memory read and the output
// register, in that order. Back-to-back pastes to the same pixel are forwarded from the
// last memory write. The frame memory is not initialized: load a pixel before reading it
// or pasting onto it with partial alpha.
module rgba_over_rgb565_compositor #(
  parameter int FRAME_MAX = roc_pkg::FRAME_MAX_DEF,
  parameter int TILE_SIZE = roc_pkg::TILE_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // col[8:0], row[17:9], tile_origin_x[28:18], tile_origin_y[39:29], src_red[47:40],
  // src_green[55:48], src_blue[63:56], src_alpha[71:64], base_pixel[87:72]
  input  logic [roc_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [roc_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_value[15:0]
  output logic [roc_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [roc_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [roc_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam int AW = roc_pkg::addr_width(FRAME_MAX);

  logic          q_full;
  logic          push;
  roc_pkg::cmd_t push_cmd;
  logic [AW-1:0] push_addr;
  logic          head_valid;
  roc_pkg::cmd_t head_cmd;
  logic [AW-1:0] head_addr;
  logic          pop;

  roc_front #(
    .FRAME_MAX (FRAME_MAX),
    .TILE_SIZE (TILE_SIZE),
    .AW        (AW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_addr   (push_addr)
  );

  roc_queue #(
    .AW (AW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_addr  (head_addr),
    .pop        (pop)
  );

  roc_back #(
    .FRAME_MAX (FRAME_MAX),
    .AW        (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_cmd      (head_cmd),
    .q_addr     (head_addr),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import roc_pkg::*;

  localparam int FRAME_W = FRAME_MAX_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 125;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic [8:0]         col;
    logic [8:0]         row;
    logic signed [10:0] ox;
    logic signed [10:0] oy;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [15:0]        base;
    logic [15:0]        exp_pixel;
    logic [1:0]         exp_status;
  } pix_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;

  // shadow frame and size setting
  logic [15:0] frame_m [FRAME_W*FRAME_W];
  bit          loaded_m [FRAME_W*FRAME_W];
  int          loaded_q [$];
  logic [9:0]  fsize_m = 10'(FRAME_SIZE_RST);

  pix_cmd_t pend_q [$];
  pix_cmd_t pixel_exp_q [$];
  pix_cmd_t cur;

  int ofr_cnt = 0;
  int acc_cnt = 0;
  int in_gap = 0;
  int rdy_gap = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int errors = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;

  rgba_over_rgb565_compositor i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic int idle_cycles(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_size();
    return (fsize_m > FRAME_W) ? FRAME_W : int'(fsize_m);
  endfunction

  function automatic bit frame_hit(input pix_cmd_t c, output int addr);
    int x;
    int y;
    if (c.kind == KIND_PASTE) begin
      x = int'(c.ox) + int'(c.col);
      y = int'(c.oy) + int'(c.row);
      if (c.col >= TILE_SIZE_DEF || c.row >= TILE_SIZE_DEF) x = -1;
    end else begin
      x = int'(c.col);
      y = int'(c.row);
    end
    addr = y * FRAME_W + x;
    return x >= 0 && y >= 0 && x < eff_size() && y < eff_size();
  endfunction

  function automatic void store_pixel(input int addr, input logic [15:0] val);
    frame_m[addr] = val;
    if (!loaded_m[addr]) begin
      loaded_m[addr] = 1'b1;
      loaded_q.push_back(addr);
    end
  endfunction

  // load, read or source-over paste onto the shadow frame, fills in the expected result
  function automatic void composite(inout pix_cmd_t c);
    int addr;
    int a;
    int dr;
    int dg;
    int db;
    int rr;
    int gg;
    int bb;
    logic [15:0] d;
    c.exp_pixel = '0;
    c.exp_status = ST_CLIPPED;
    if (c.kind == KIND_NONE || !frame_hit(c, addr)) return;
    d = frame_m[addr];
    if (c.kind == KIND_LOAD) begin
      store_pixel(addr, c.base);
      c.exp_pixel = c.base;
      c.exp_status = ST_WRITTEN;
    end else if (c.kind == KIND_READ) begin
      c.exp_pixel = d;
      c.exp_status = ST_READ;
    end else if (c.alpha == 8'd0) begin
      c.exp_pixel = d;
      c.exp_status = ST_CLEAR;
    end else begin
      a = int'(c.alpha);
      rr = int'(c.red);
      gg = int'(c.green);
      bb = int'(c.blue);
      if (a < 255) begin
        dr = int'(d[15:11]) * 255 / 31;
        dg = int'(d[10:5]) * 255 / 63;
        db = int'(d[4:0]) * 255 / 31;
        rr = (rr * a + dr * (255 - a)) / 255;
        gg = (gg * a + dg * (255 - a)) / 255;
        bb = (bb * a + db * (255 - a)) / 255;
      end
      c.exp_pixel = {rr[7:3], gg[7:2], bb[7:3]};
      store_pixel(addr, c.exp_pixel);
      c.exp_status = ST_WRITTEN;
    end
  endfunction

  function automatic void issue(input pix_cmd_t c);
    composite(c);
    pend_q.push_back(c);
  endfunction

  function automatic pix_cmd_t cmd(input logic [1:0] kind, input int col, input int row,
                                   input int ox, input int oy, input logic [31:0] rgba,
                                   input logic [15:0] base);
    pix_cmd_t c;
    c.kind = kind;
    c.col = 9'(col);
    c.row = 9'(row);
    c.ox = 11'(ox);
    c.oy = 11'(oy);
    c.red = rgba[31:24];
    c.green = rgba[23:16];
    c.blue = rgba[15:8];
    c.alpha = rgba[7:0];
    c.base = base;
    return c;
  endfunction

  function automatic pix_cmd_t random_cmd();
    pix_cmd_t c;
    int addr;
    int eff;
    int pick;
    eff = eff_size();
    c.col = 9'($urandom);
    c.row = 9'($urandom);
    c.ox = 11'($urandom);
    c.oy = 11'($urandom);
    c.red = 8'($urandom);
    c.green = 8'($urandom);
    c.blue = 8'($urandom);
    c.alpha = 8'($urandom);
    c.base = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.kind = KIND_LOAD;
      if (eff > 0 && pick < 22) begin
        c.col = 9'($urandom_range(0, eff - 1));
        c.row = 9'($urandom_range(0, eff - 1));
      end
    end else if (pick < 95) begin
      c.kind = (pick < 70) ? KIND_PASTE : KIND_READ;
      if (loaded_q.size() > 0 && $urandom_range(0, 4) != 0) begin
        addr = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        if (c.kind == KIND_READ) begin
          c.col = 9'(addr % FRAME_W);
          c.row = 9'(addr / FRAME_W);
        end else begin
          c.ox = 11'(addr % FRAME_W - int'(c.col));
          c.oy = 11'(addr / FRAME_W - int'(c.row));
        end
      end
      case ($urandom_range(0, 3))
        0: c.alpha = 8'd0;
        1: c.alpha = 8'd255;
        default: ;
      endcase
    end else begin
      c.kind = KIND_NONE;
    end
    // never look at a pixel that was not loaded
    if ((c.kind == KIND_READ || c.kind == KIND_PASTE) && frame_hit(c, addr) &&
        !loaded_m[addr]) begin
      if (c.kind == KIND_READ) c.kind = KIND_LOAD;
      else c.alpha = 8'd255;
    end
    return c;
  endfunction

  // wait until every transaction has come back, then let the pipeline empty
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pend_q.size() != 0 || acc_cnt != ofr_cnt || pixel_exp_q.size() != 0);
    repeat (8) @(posedge clk);
    #1;
  endtask

  task automatic set_frame_size(input logic [9:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fsize_m = val;
    #1;
  endtask

  // input driver
  always @(negedge clk) begin
    pix_cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && acc_cnt != ofr_cnt)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt = pend_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.kind;
        in_tdata <= {nxt.base, nxt.alpha, nxt.blue, nxt.green, nxt.red,
                     nxt.oy, nxt.ox, nxt.row, nxt.col};
        cur <= nxt;
        ofr_cnt <= ofr_cnt + 1;
        in_gap <= idle_cycles(in_steady);
        if ($urandom_range(0, 31) == 0) in_steady <= !in_steady;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result ready, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap <= rdy_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rdy_gap <= idle_cycles(out_steady);
      if ($urandom_range(0, 31) == 0) out_steady <= !out_steady;
    end
  end

  // input transactions arm expectations, output transactions are checked
  always @(posedge clk) begin
    pix_cmd_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pixel_exp_q.push_back(cur);
        acc_cnt <= acc_cnt + 1;
      end
      if (out_tvalid && out_tready) begin
        if (pixel_exp_q.size() == 0) begin
          $error("unexpected transaction: pixel_value %04h status %0d", out_tdata, out_tuser);
          errors++;
        end else begin
          e = pixel_exp_q.pop_front();
          if (out_tdata !== e.exp_pixel) begin
            $error("pixel_value: expected %04h, actual %04h", e.exp_pixel, out_tdata);
            errors++;
          end
          if (out_tuser !== e.exp_status) begin
            $error("status: expected %0d, actual %0d", e.exp_status, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int sizes [8];
    sizes = '{1, 0, 1023, 512, 0, 64, 0, 0};
    sizes[4] = $urandom_range(2, 511);
    sizes[6] = $urandom_range(513, 1022);
    sizes[7] = $urandom_range(0, 1023);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    #1;

    // corners, every kind, alpha extremes, clipping on all sides
    issue(cmd(KIND_LOAD, 0, 0, 0, 0, 32'h0, 16'hFFFF));
    issue(cmd(KIND_LOAD, 511, 511, 0, 0, 32'h0, 16'h0000));
    issue(cmd(KIND_LOAD, 511, 0, 0, 0, 32'h0, 16'h1234));
    issue(cmd(KIND_LOAD, 0, 511, 0, 0, 32'h0, 16'h8001));
    issue(cmd(KIND_READ, 0, 0, 0, 0, 32'h0, 16'h0));
    issue(cmd(KIND_READ, 511, 511, 0, 0, 32'h0, 16'h0));
    issue(cmd(KIND_PASTE, 5, 0, -5, 0, 32'hFFFFFF00, 16'h0));
    issue(cmd(KIND_PASTE, 511, 511, 0, 0, 32'hFF00FFFF, 16'h0));
    issue(cmd(KIND_PASTE, 0, 0, 0, 0, 32'h0AC81E80, 16'h0));
    issue(cmd(KIND_PASTE, 0, 0, 511, 0, 32'hFFFFFF01, 16'h0));
    issue(cmd(KIND_PASTE, 0, 0, 511, 0, 32'h00FF00FE, 16'h0));
    issue(cmd(KIND_PASTE, 0, 0, 511, 0, 32'h8040204D, 16'h0));
    issue(cmd(KIND_PASTE, 0, 0, -1024, 0, 32'hFFFFFFFF, 16'h0));
    issue(cmd(KIND_PASTE, 511, 511, 1023, 1023, 32'hFFFFFFFF, 16'h0));
    issue(cmd(KIND_PASTE, 1, 0, -1, -1, 32'hFFFFFFFF, 16'h0));
    issue(cmd(KIND_PASTE, 511, 0, 1, 0, 32'hFFFFFF80, 16'h0));
    issue(cmd(KIND_NONE, 77, 300, -3, 9, 32'h12345678, 16'hBEEF));
    issue(cmd(KIND_READ, 511, 0, 0, 0, 32'h0, 16'h0));
    issue(cmd(KIND_READ, 0, 511, 0, 0, 32'h0, 16'h0));
    issue(cmd(KIND_LOAD, 0, 511, 0, 0, 32'h0, 16'h5555));
    issue(cmd(KIND_READ, 0, 511, 0, 0, 32'h0, 16'h0));
    issue(cmd(KIND_PASTE, 300, 11, -300, 500, 32'hC03060C8, 16'h0));

    for (int p = 0; p < 8; p++) begin
      settle();
      set_frame_size(10'(sizes[p]));
      for (int i = 0; i < PHASE_ITEMS; i++) issue(random_cmd());
      if (p == 2 || p == 6) hold_req++;
    end

    settle();
    if (errors == 0 && pixel_exp_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
